// ===== hdl/kalman_angle_bias_filter_unit_macros.svh =====
// Assertion macros used by the filter control module (kabf_ctrl).
`ifndef KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KABF_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("kabf check failed");
`define KABF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kabf sequence check failed");
`else
`define KABF_ASSERT(label, clk, rst_n, cond)
`define KABF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/kabf_pkg.sv =====
package kabf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int IO_WIDTH   = 32;
    localparam int TS_WIDTH   = 16;
    localparam int CFG_WIDTH  = 31;
    localparam int ADDR_WIDTH = 4;

    localparam logic [CFG_WIDTH-1:0] ANGLE_NOISE_RESET = 31'd66;
    localparam logic [CFG_WIDTH-1:0] BIAS_NOISE_RESET  = 31'd197;
    localparam logic [CFG_WIDTH-1:0] MEAS_NOISE_RESET  = 31'd1966;

    typedef enum logic [1:0] {
        REG_ANGLE_NOISE = 2'd0,
        REG_BIAS_NOISE  = 2'd1,
        REG_MEAS_NOISE  = 2'd2
    } reg_idx_t;

    // One arithmetic step of an update, in issue order.
    typedef enum logic [3:0] {
        OP_RATE,
        OP_M11,
        OP_P00,
        OP_P11,
        OP_K0,
        OP_K1,
        OP_ANGLE,
        OP_BIAS,
        OP_P10C,
        OP_P00C,
        OP_P11C,
        OP_P01C
    } op_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic publish;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

endpackage

// ===== hdl/kabf_mul.sv =====
module kabf_mul #(
    parameter int DW = kabf_pkg::DATA_WIDTH,
    parameter int FW = kabf_pkg::FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [DW+1:0]      a,
    input  logic signed [DW+1:0]      b,
    output logic                      done,
    output logic                      neg,
    output logic [2*(DW+2)-1:0]       mag
);

    localparam int W  = DW + 2;
    localparam int H  = (W + 1) / 2;
    localparam int HI = W - H;
    localparam int MW = 2 * W;

    typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI, PH_OUT} phase_t;

    phase_t          phase_reg;
    logic [W-1:0]    ma_reg;
    logic [W-1:0]    mb_reg;
    logic            neg_reg;
    logic [MW-1:0]   acc_reg;
    logic [MW-1:0]   mag_reg;
    logic            done_reg;

    logic [W-1:0]    a_mag;
    logic [W-1:0]    b_mag;
    logic [W+H-1:0]  prod_lo;
    logic [W+HI-1:0] prod_hi;

    assign a_mag   = a[W-1] ? W'(-a) : W'(a);
    assign b_mag   = b[W-1] ? W'(-b) : W'(b);
    assign prod_lo = ma_reg * mb_reg[H-1:0];
    assign prod_hi = ma_reg * mb_reg[W-1:H];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            ma_reg    <= '0;
            mb_reg    <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            mag_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        ma_reg    <= a_mag;
                        mb_reg    <= b_mag;
                        neg_reg   <= a[W-1] ^ b[W-1];
                        phase_reg <= PH_LO;
                    end
                end
                PH_LO:
                begin
                    acc_reg   <= MW'(prod_lo);
                    phase_reg <= PH_HI;
                end
                PH_HI:
                begin
                    acc_reg   <= acc_reg + (MW'(prod_hi) << H);
                    phase_reg <= PH_OUT;
                end
                PH_OUT:
                begin
                    mag_reg   <= acc_reg >> FW;
                    done_reg  <= 1'b1;
                    phase_reg <= PH_IDLE;
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign neg  = neg_reg;
    assign mag  = mag_reg;

endmodule

// ===== hdl/kabf_div.sv =====
module kabf_div #(
    parameter int DW = kabf_pkg::DATA_WIDTH,
    parameter int FW = kabf_pkg::FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [DW-1:0]      num,
    input  logic signed [DW:0]        den,
    output logic                      done,
    output logic                      neg,
    output logic [2*(DW+2)-1:0]       mag
);

    localparam int NB = DW + FW;
    localparam int CW = $clog2(NB + 1);
    localparam int MW = 2 * (DW + 2);

    typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_OUT} phase_t;

    phase_t         phase_reg;
    logic [CW-1:0]  cnt_reg;
    logic [NB-1:0]  n_reg;
    logic [NB-1:0]  q_reg;
    logic [DW:0]    r_reg;
    logic [DW:0]    b_reg;
    logic           neg_reg;
    logic           zero_reg;
    logic [MW-1:0]  mag_reg;
    logic           done_reg;

    logic [DW-1:0]  a_mag;
    logic [DW:0]    d_mag;
    logic [DW+1:0]  r_shift;
    logic [DW+1:0]  r_diff;
    logic           q_bit;

    assign a_mag   = num[DW-1] ? DW'(-num) : DW'(num);
    assign d_mag   = den[DW] ? (DW+1)'(-den) : (DW+1)'(den);
    assign r_shift = {r_reg, n_reg[NB-1]};
    assign q_bit   = (r_shift >= (DW+2)'(b_reg));
    assign r_diff  = r_shift - (DW+2)'(b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= DV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            n_reg     <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
            b_reg     <= '0;
            neg_reg   <= 1'b0;
            zero_reg  <= 1'b0;
            mag_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= {a_mag, {FW{1'b0}}};
                        q_reg     <= '0;
                        r_reg     <= '0;
                        b_reg     <= d_mag;
                        neg_reg   <= num[DW-1] ^ den[DW];
                        zero_reg  <= (den == '0);
                        cnt_reg   <= CW'(NB);
                        phase_reg <= DV_RUN;
                    end
                end
                DV_RUN:
                begin
                    // one quotient bit per cycle
                    r_reg   <= q_bit ? r_diff[DW:0] : r_shift[DW:0];
                    q_reg   <= {q_reg[NB-2:0], q_bit};
                    n_reg   <= {n_reg[NB-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        phase_reg <= DV_OUT;
                    end
                end
                DV_OUT:
                begin
                    mag_reg   <= zero_reg ? '0 : MW'(q_reg);
                    done_reg  <= 1'b1;
                    phase_reg <= DV_IDLE;
                end
                default: phase_reg <= DV_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign neg  = neg_reg;
    assign mag  = mag_reg;

endmodule

// ===== hdl/kabf_dp.sv =====
module kabf_dp #(
    parameter int DW = kabf_pkg::DATA_WIDTH,
    parameter int FW = kabf_pkg::FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  kabf_pkg::cmd_t                          cmd,
    output kabf_pkg::status_t                       status,
    input  logic signed [kabf_pkg::IO_WIDTH-1:0]    measured_angle,
    input  logic signed [kabf_pkg::IO_WIDTH-1:0]    measured_rate,
    input  logic [kabf_pkg::TS_WIDTH-1:0]           time_step,
    input  logic signed [DW-1:0]                    angle_noise,
    input  logic signed [DW-1:0]                    bias_noise,
    input  logic signed [DW-1:0]                    meas_noise,
    output logic signed [kabf_pkg::IO_WIDTH-1:0]    filtered_angle,
    output logic signed [kabf_pkg::IO_WIDTH-1:0]    corrected_rate,
    output logic signed [kabf_pkg::IO_WIDTH-1:0]    bias_estimate
);

    localparam int W  = DW + 2;
    localparam int XW = DW + 3;
    localparam int SW = DW + 1;
    localparam int MW = 2 * W;
    localparam int IW = kabf_pkg::IO_WIDTH;
    localparam int TW = kabf_pkg::TS_WIDTH;
    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [MW-1:0] LIM_POS = (MW'(1) << (DW - 1)) - MW'(1);
    localparam logic [MW-1:0] LIM_NEG = MW'(1) << (DW - 1);

    function automatic logic signed [DW-1:0] sat(input logic signed [XW-1:0] v);
        if (v > XW'(DMAX))
            return DMAX;
        else if (v < XW'(DMIN))
            return DMIN;
        else
            return DW'(v);
    endfunction

    function automatic logic signed [DW-1:0] sat_mag(input logic n, input logic [MW-1:0] m);
        if (n)
            return (m > LIM_NEG) ? DMIN : DW'(-m);
        else
            return (m > LIM_POS) ? DMAX : DW'(m);
    endfunction

    function automatic logic signed [DW-1:0] from_io(input logic signed [IW-1:0] v);
        logic signed [DW+IW-1:0] w;
        w = (DW+IW)'(v);
        if (w > (DW+IW)'(DMAX))
            return DMAX;
        else if (w < (DW+IW)'(DMIN))
            return DMIN;
        else
            return DW'(w);
    endfunction

    function automatic logic [IW-1:0] to_io(input logic signed [DW-1:0] v);
        logic signed [DW+IW-1:0] w;
        w = (DW+IW)'(v);
        return w[IW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] conv_dt(input logic [TW-1:0] ts);
        logic [DW+TW+31:0] w;
        w = ((DW+TW+32)'(ts) << FW) >> TW;
        if (w > (DW+TW+32)'(DMAX))
            return DMAX;
        else
            return DW'(w);
    endfunction

    logic signed [DW-1:0] ae_reg, rb_reg, ur_reg;
    logic signed [DW-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [DW-1:0] m11_reg, k0_reg, k1_reg, ma_reg, dt_reg;
    logic signed [SW-1:0] y_reg;
    logic [IW-1:0]        fa_reg, cr_reg, be_reg;

    logic signed [W-1:0]  mul_a, mul_b, inner;
    logic signed [DW-1:0] div_num;
    logic signed [SW-1:0] div_den;
    logic                 is_div;
    logic                 mul_done, div_done, mul_neg, div_neg;
    logic [MW-1:0]        mul_mag, div_mag;
    logic signed [DW-1:0] res;

    assign inner   = W'(m11_reg) - W'(p01_reg) - W'(p10_reg) + W'(angle_noise);
    assign div_den = SW'(p00_reg) + SW'(meas_noise);
    assign is_div  = (cmd.op == kabf_pkg::OP_K0) || (cmd.op == kabf_pkg::OP_K1);
    assign div_num = (cmd.op == kabf_pkg::OP_K1) ? p10_reg : p00_reg;

    always_comb
    begin
        mul_a = W'(dt_reg);
        mul_b = W'(ur_reg);
        case (cmd.op)
            kabf_pkg::OP_RATE:  begin mul_a = W'(dt_reg); mul_b = W'(ur_reg);  end
            kabf_pkg::OP_M11:   begin mul_a = W'(dt_reg); mul_b = W'(p11_reg); end
            kabf_pkg::OP_P00:   begin mul_a = W'(dt_reg); mul_b = inner;       end
            kabf_pkg::OP_P11:   begin mul_a = W'(bias_noise); mul_b = W'(dt_reg); end
            kabf_pkg::OP_ANGLE: begin mul_a = W'(k0_reg); mul_b = W'(y_reg);   end
            kabf_pkg::OP_BIAS:  begin mul_a = W'(k1_reg); mul_b = W'(y_reg);   end
            kabf_pkg::OP_P10C:  begin mul_a = W'(k1_reg); mul_b = W'(p00_reg); end
            kabf_pkg::OP_P00C:  begin mul_a = W'(k0_reg); mul_b = W'(p00_reg); end
            kabf_pkg::OP_P11C:  begin mul_a = W'(k1_reg); mul_b = W'(p01_reg); end
            kabf_pkg::OP_P01C:  begin mul_a = W'(k0_reg); mul_b = W'(p01_reg); end
            default:            begin mul_a = W'(dt_reg); mul_b = W'(ur_reg);  end
        endcase
    end

    kabf_mul #(.DW(DW), .FW(FW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start && !is_div),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .neg   (mul_neg),
        .mag   (mul_mag)
    );

    kabf_div #(.DW(DW), .FW(FW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start && is_div),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .neg   (div_neg),
        .mag   (div_mag)
    );

    assign status.done = mul_done || div_done;
    assign res = div_done ? sat_mag(div_neg, div_mag) : sat_mag(mul_neg, mul_mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ae_reg  <= '0;
            rb_reg  <= '0;
            ur_reg  <= '0;
            p00_reg <= '0;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= '0;
        end
        else if (cmd.clear)
        begin
            ae_reg  <= '0;
            rb_reg  <= '0;
            ur_reg  <= '0;
            p00_reg <= '0;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= '0;
        end
        else if (cmd.load)
        begin
            ur_reg <= sat(XW'(from_io(measured_rate)) - XW'(rb_reg));
        end
        else if (status.done)
        begin
            case (cmd.op)
                kabf_pkg::OP_RATE:  ae_reg <= sat(XW'(ae_reg) + XW'(res));
                kabf_pkg::OP_P00:
                begin
                    p00_reg <= sat(XW'(p00_reg) + XW'(res));
                    p01_reg <= sat(XW'(p01_reg) - XW'(m11_reg));
                    p10_reg <= sat(XW'(p10_reg) - XW'(m11_reg));
                end
                kabf_pkg::OP_P11:   p11_reg <= sat(XW'(p11_reg) + XW'(res));
                kabf_pkg::OP_ANGLE: ae_reg  <= sat(XW'(ae_reg) + XW'(res));
                kabf_pkg::OP_BIAS:  rb_reg  <= sat(XW'(rb_reg) + XW'(res));
                kabf_pkg::OP_P10C:  p10_reg <= sat(XW'(p10_reg) - XW'(res));
                kabf_pkg::OP_P00C:  p00_reg <= sat(XW'(p00_reg) - XW'(res));
                kabf_pkg::OP_P11C:  p11_reg <= sat(XW'(p11_reg) - XW'(res));
                kabf_pkg::OP_P01C:  p01_reg <= sat(XW'(p01_reg) - XW'(res));
                default: ;
            endcase
        end
    end

    // working values and output word; no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ma_reg <= from_io(measured_angle);
            dt_reg <= conv_dt(time_step);
        end
        if (status.done)
        begin
            case (cmd.op)
                kabf_pkg::OP_M11: m11_reg <= res;
                kabf_pkg::OP_P11: y_reg   <= SW'(ma_reg) - SW'(ae_reg);
                kabf_pkg::OP_K0:  k0_reg  <= res;
                kabf_pkg::OP_K1:  k1_reg  <= res;
                default: ;
            endcase
        end
        if (cmd.publish)
        begin
            fa_reg <= to_io(ae_reg);
            cr_reg <= to_io(ur_reg);
            be_reg <= to_io(rb_reg);
        end
    end

    assign filtered_angle = fa_reg;
    assign corrected_rate = cr_reg;
    assign bias_estimate  = be_reg;

endmodule

// ===== hdl/kabf_ctrl.sv =====
`include "kalman_angle_bias_filter_unit_macros.svh"

module kabf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    output logic               out_valid,
    input  logic               out_ready,
    output kabf_pkg::cmd_t     cmd,
    input  kabf_pkg::status_t  status
);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN} state_t;

    state_t          state_reg;
    kabf_pkg::op_t   op_reg;
    logic            out_valid_reg;
    logic            accept;
    logic            publish;

    function automatic kabf_pkg::op_t next_op(input kabf_pkg::op_t op);
        unique case (op)
            kabf_pkg::OP_RATE:  return kabf_pkg::OP_M11;
            kabf_pkg::OP_M11:   return kabf_pkg::OP_P00;
            kabf_pkg::OP_P00:   return kabf_pkg::OP_P11;
            kabf_pkg::OP_P11:   return kabf_pkg::OP_K0;
            kabf_pkg::OP_K0:    return kabf_pkg::OP_K1;
            kabf_pkg::OP_K1:    return kabf_pkg::OP_ANGLE;
            kabf_pkg::OP_ANGLE: return kabf_pkg::OP_BIAS;
            kabf_pkg::OP_BIAS:  return kabf_pkg::OP_P10C;
            kabf_pkg::OP_P10C:  return kabf_pkg::OP_P00C;
            kabf_pkg::OP_P00C:  return kabf_pkg::OP_P11C;
            kabf_pkg::OP_P11C:  return kabf_pkg::OP_P01C;
            default:            return kabf_pkg::OP_RATE;
        endcase
    endfunction

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign publish  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign cmd.load    = accept && !action;
    assign cmd.clear   = accept && action;
    assign cmd.start   = (state_reg == S_ISSUE);
    assign cmd.publish = publish;
    assign cmd.op      = op_reg;
    assign out_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= kabf_pkg::OP_RATE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // hold the result word until taken
            if (publish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= kabf_pkg::OP_RATE;
                        state_reg <= action ? S_FIN : S_ISSUE;
                    end
                end
                S_ISSUE: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (status.done)
                    begin
                        if (op_reg == kabf_pkg::OP_P01C)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            op_reg    <= next_op(op_reg);
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_FIN:
                begin
                    if (publish)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `KABF_ASSERT(a_done_only_waiting, clk, rst_n, !status.done || (state_reg == S_WAIT))
    `KABF_ASSERT_NEXT(a_publish_shows, clk, rst_n, publish, out_valid_reg)
    `KABF_ASSERT_NEXT(a_clear_skips_math, clk, rst_n, accept && action, state_reg == S_FIN)

endmodule

// ===== hdl/kalman_angle_bias_filter_unit.sv =====
// Two-state angle/bias Kalman filter, signed fixed point.
// Input channel (in_valid/in_ready): one word per sample holding action,
// measured_angle, measured_rate and time_step. action 1 clears the state and
// returns an all-zero result; action 0 runs one filter update.
// Output channel (out_valid/out_ready): one word per input word with
// filtered_angle, corrected_rate and bias_estimate.
// An update is ten multiplies on one shared two-pass multiplier plus two gain
// divides on a one-bit-per-cycle divider, issued one at a time; the output word
// is registered when the last step finishes, and the block then returns to idle
// for the next input word. A clear skips the arithmetic and goes straight to
// publishing its all-zero word. One sample is in flight at a time.
// A finished word waits in the output register; the next input word is taken
// while it waits, and the block stalls at the end of that update until the
// receiver takes the earlier word.
// Noise registers sit on an APB port at byte addresses 0, 4 and 8; the user must
// write them only while the block is idle, which the block does not enforce.
// Reset clears angle, bias, rate and covariance and loads the default noise
// values; no output word is pending after reset.
module kalman_angle_bias_filter_unit #(
    parameter int DATA_WIDTH = kabf_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = kabf_pkg::FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [kabf_pkg::ADDR_WIDTH-1:0]         paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    action,
    input  logic signed [kabf_pkg::IO_WIDTH-1:0]    measured_angle,
    input  logic signed [kabf_pkg::IO_WIDTH-1:0]    measured_rate,
    input  logic [kabf_pkg::TS_WIDTH-1:0]           time_step,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [kabf_pkg::IO_WIDTH-1:0]    filtered_angle,
    output logic signed [kabf_pkg::IO_WIDTH-1:0]    corrected_rate,
    output logic signed [kabf_pkg::IO_WIDTH-1:0]    bias_estimate
);

    localparam int DW = DATA_WIDTH;
    localparam int CW = kabf_pkg::CFG_WIDTH;
    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};

    function automatic logic signed [DW-1:0] cfg_fit(input logic [CW-1:0] v);
        logic [DW+CW-1:0] w;
        w = (DW+CW)'(v);
        if (w > (DW+CW)'(DMAX))
            return DMAX;
        else
            return DW'(w);
    endfunction

    function automatic logic [31:0] cfg_read(input logic signed [DW-1:0] v);
        logic [DW+31:0] w;
        w = (DW+32)'(v);
        return w[31:0];
    endfunction

    logic signed [DW-1:0]  angle_noise_reg, bias_noise_reg, meas_noise_reg;
    kabf_pkg::reg_idx_t    reg_idx;
    logic                  cfg_write;
    kabf_pkg::cmd_t        cmd;
    kabf_pkg::status_t     status;

    assign pready    = 1'b1;
    assign reg_idx   = kabf_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_noise_reg <= cfg_fit(kabf_pkg::ANGLE_NOISE_RESET);
            bias_noise_reg  <= cfg_fit(kabf_pkg::BIAS_NOISE_RESET);
            meas_noise_reg  <= cfg_fit(kabf_pkg::MEAS_NOISE_RESET);
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                kabf_pkg::REG_ANGLE_NOISE: angle_noise_reg <= cfg_fit(pwdata[CW-1:0]);
                kabf_pkg::REG_BIAS_NOISE:  bias_noise_reg  <= cfg_fit(pwdata[CW-1:0]);
                kabf_pkg::REG_MEAS_NOISE:  meas_noise_reg  <= cfg_fit(pwdata[CW-1:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            kabf_pkg::REG_ANGLE_NOISE: prdata = cfg_read(angle_noise_reg);
            kabf_pkg::REG_BIAS_NOISE:  prdata = cfg_read(bias_noise_reg);
            kabf_pkg::REG_MEAS_NOISE:  prdata = cfg_read(meas_noise_reg);
            default:                   prdata = '0;
        endcase
    end

    kabf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    kabf_dp #(.DW(DATA_WIDTH), .FW(FRAC_BITS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .measured_angle (measured_angle),
        .measured_rate  (measured_rate),
        .time_step      (time_step),
        .angle_noise    (angle_noise_reg),
        .bias_noise     (bias_noise_reg),
        .meas_noise     (meas_noise_reg),
        .filtered_angle (filtered_angle),
        .corrected_rate (corrected_rate),
        .bias_estimate  (bias_estimate)
    );

endmodule
